/* hdl/rrls_pkg.sv */
`timescale 1ns / 1ps
package rrls_pkg;
	localparam int unsigned TABLE_ENTRIES_DEF = 1024;
	localparam int unsigned TICKET_BITS_DEF = 8;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned ST_W = 3;
	localparam int unsigned OUT_W = 3;
	localparam int unsigned LCG_W = 31;
	localparam logic [30:0] LCG_MOD = 31'h7fffffff;
	localparam logic [15:0] LCG_MUL = 16'd48271;

	localparam logic [ST_W-1:0] ST_DYING = 3'd1;
	localparam logic [ST_W-1:0] ST_RUNNABLE = 3'd2;
	localparam logic [ST_W-1:0] ST_RUNNING = 3'd3;

	localparam logic [OUT_W-1:0] OUT_WRITTEN = 3'd0;
	localparam logic [OUT_W-1:0] OUT_RUN = 3'd1;
	localparam logic [OUT_W-1:0] OUT_RERUN = 3'd2;
	localparam logic [OUT_W-1:0] OUT_HALT = 3'd3;
	localparam logic [OUT_W-1:0] OUT_NOLIVE = 3'd4;

	typedef enum logic [3:0] {
		S_IDLE,
		S_CLEAR,
		S_SCAN,
		S_LCG_MUL,
		S_LCG_RED,
		S_MOD,
		S_PICK,
		S_CUR,
		S_DECIDE,
		S_DONE
	} state_t;
endpackage

/* hdl/round_robin_lottery_scheduler_top.sv */
`timescale 1ns / 1ps
// Round-robin / lottery task scheduler.
// Input channel: an item is taken at a clock edge with start high and busy
// low. func 0 writes one table entry (status, tickets); func 1 asks for the
// next task to run, given the current task if any.
// Result channel: done pulses for one cycle with outcome and chosen_index.
// The receiver cannot stall; every item yields exactly one result.
// policy_mode (cfg_we/cfg_wdata) picks round-robin (0) or lottery (1); write
// it only while busy is low.
// A write goes straight to the done state. A round-robin yield sweeps the
// table once. A lottery yield sweeps the table to sum tickets and, if the
// total is nonzero, runs a 31-bit modular multiply by 48271 in two steps, a
// remainder by the ticket total, and a second sweep. The next item can be
// taken at the edge that takes the result. The sweeps go through the
// single-port table memory.
// After reset the block clears the table one entry per cycle with busy
// high; the generator restarts at seed one.
module round_robin_lottery_scheduler_top #(
	parameter int unsigned TABLE_ENTRIES = rrls_pkg::TABLE_ENTRIES_DEF,
	parameter int unsigned TICKET_BITS = rrls_pkg::TICKET_BITS_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cfg_we,
	input logic cfg_wdata,
	input logic func,
	input logic [9:0] entry_index,
	input logic [2:0] entry_status,
	input logic [7:0] entry_tickets,
	input logic has_current,
	input logic [9:0] current_index,
	output logic done,
	output logic [2:0] outcome,
	output logic [9:0] chosen_index
);
	localparam int unsigned AW = $clog2(TABLE_ENTRIES);
	localparam int unsigned CW = $clog2(TABLE_ENTRIES + 1);
	localparam int unsigned SW = TICKET_BITS + CW;
	localparam int unsigned EW = rrls_pkg::ST_W + TICKET_BITS;

	rrls_pkg::state_t state_q, state_d;
	logic [EW-1:0] mem [TABLE_ENTRIES];
	logic [EW-1:0] rd_s1;
	logic [AW-1:0] addr;
	logic we;
	logic [EW-1:0] wdata;
	logic policy_q;
	logic func_q, cur_ok_q;
	logic [9:0] cur_q;
	logic [AW-1:0] wr_idx_q;
	logic wr_ok_q;
	logic [EW-1:0] wr_data_q;
	logic [CW-1:0] cnt_q;
	logic [AW-1:0] pos_q;
	logic rd_vld_q;
	logic [AW-1:0] rd_pos_q;
	logic [SW-1:0] total_q, sum_q, draw_q;
	logic found_q, live_q;
	logic [AW-1:0] pick_q;
	logic [30:0] lcg_q;
	logic [46:0] prod_q;
	logic [2:0] out_q;
	logic [9:0] idx_q;
	logic done_q;
	logic div_go, div_done;
	logic [SW-1:0] div_rem;
	logic [2:0] rd_st;
	logic [TICKET_BITS-1:0] rd_tk;
	logic rd_runnable;
	logic [SW-1:0] sum_next;
	logic [32:0] fold;
	logic [31:0] fold2;
	logic [30:0] lcg_nxt;
	logic [AW-1:0] last_pos;

	assign rd_st = rd_s1[EW-1 -: 3];
	assign rd_tk = rd_s1[TICKET_BITS-1:0];
	assign rd_runnable = rd_vld_q && rd_st == rrls_pkg::ST_RUNNABLE;
	assign sum_next = sum_q + SW'(rd_tk);
	assign last_pos = AW'(TABLE_ENTRIES - 1);

	// Mod 2^31-1 fold: high part added to low part, one correction.
	always_comb begin
		fold = {2'b00, prod_q[30:0]} + {17'd0, prod_q[46:31]};
		fold2 = fold[31:0] - {1'b0, rrls_pkg::LCG_MOD};
		lcg_nxt = fold2[31] ? fold[30:0] : fold2[30:0];
	end

	rrls_divider #(.W(31), .DW(SW)) u_div (
		.clk(clk), .arst_n(arst_n), .go(div_go),
		.dividend(lcg_nxt), .divisor(total_q),
		.done(div_done), .remainder(div_rem)
	);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			rrls_pkg::S_CLEAR: if (cnt_q == CW'(TABLE_ENTRIES - 1)) state_d = rrls_pkg::S_IDLE;
			rrls_pkg::S_IDLE: if (start) state_d = func ? rrls_pkg::S_SCAN : rrls_pkg::S_DONE;
			rrls_pkg::S_SCAN: if (cnt_q == CW'(TABLE_ENTRIES) && !rd_vld_q)
				state_d = (policy_q && total_q != '0) ? rrls_pkg::S_LCG_MUL
					: rrls_pkg::S_CUR;
			rrls_pkg::S_LCG_MUL: state_d = rrls_pkg::S_LCG_RED;
			rrls_pkg::S_LCG_RED: state_d = rrls_pkg::S_MOD;
			rrls_pkg::S_MOD: if (div_done) state_d = rrls_pkg::S_PICK;
			rrls_pkg::S_PICK: if ((cnt_q == CW'(TABLE_ENTRIES) && !rd_vld_q) || found_q)
				state_d = rrls_pkg::S_CUR;
			rrls_pkg::S_CUR: state_d = rrls_pkg::S_DECIDE;
			rrls_pkg::S_DECIDE: state_d = rrls_pkg::S_DONE;
			rrls_pkg::S_DONE: state_d = rrls_pkg::S_IDLE;
			default: state_d = rrls_pkg::S_IDLE;
		endcase
	end

	// Memory port control.
	always_comb begin
		we = 1'b0;
		wdata = wr_data_q;
		addr = pos_q;
		div_go = 1'b0;
		case (state_q)
			rrls_pkg::S_CLEAR: begin
				we = 1'b1;
				wdata = '0;
				addr = cnt_q[AW-1:0];
			end
			rrls_pkg::S_DONE: begin
				we = !func_q && wr_ok_q;
				addr = wr_idx_q;
			end
			rrls_pkg::S_CUR: addr = cur_q[AW-1:0];
			rrls_pkg::S_LCG_RED: div_go = 1'b0;
			rrls_pkg::S_MOD: div_go = 1'b0;
			default: ;
		endcase
		if (state_q == rrls_pkg::S_LCG_RED) div_go = 1'b1;
	end

	always_ff @(posedge clk) begin
		if (we) mem[addr] <= wdata;
		rd_s1 <= mem[addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rrls_pkg::S_CLEAR;
			policy_q <= 1'b0;
			lcg_q <= 31'd1;
			cnt_q <= '0;
			rd_vld_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q <= state_q == rrls_pkg::S_DONE;
			if (cfg_we) policy_q <= cfg_wdata;
			rd_vld_q <= 1'b0;
			case (state_q)
				rrls_pkg::S_CLEAR: cnt_q <= (cnt_q == CW'(TABLE_ENTRIES - 1)) ? '0 : cnt_q + 1'b1;
				rrls_pkg::S_IDLE: cnt_q <= '0;
				rrls_pkg::S_SCAN, rrls_pkg::S_PICK: if (cnt_q != CW'(TABLE_ENTRIES)) begin
					cnt_q <= cnt_q + 1'b1;
					rd_vld_q <= !(state_q == rrls_pkg::S_PICK && found_q);
				end else if (state_d != state_q) cnt_q <= '0;
				rrls_pkg::S_LCG_RED: lcg_q <= lcg_nxt;
				default: ;
			endcase
		end
	end

	// Sweep datapath: sums, search, live flag; decision.
	always_ff @(posedge clk) begin
		case (state_q)
			rrls_pkg::S_IDLE: begin
				func_q <= func;
				cur_ok_q <= has_current && (32'(current_index) < TABLE_ENTRIES);
				cur_q <= current_index;
				wr_ok_q <= 32'(entry_index) < TABLE_ENTRIES;
				wr_idx_q <= entry_index[AW-1:0];
				wr_data_q <= {entry_status, TICKET_BITS'(entry_tickets)};
				pos_q <= (has_current && (32'(current_index) < TABLE_ENTRIES)
					&& current_index[AW-1:0] != last_pos) ? current_index[AW-1:0] + 1'b1 : '0;
				total_q <= '0;
				sum_q <= '0;
				found_q <= 1'b0;
				live_q <= 1'b0;
				out_q <= rrls_pkg::OUT_WRITTEN;
				idx_q <= '0;
			end
			rrls_pkg::S_SCAN: begin
				rd_pos_q <= pos_q;
				pos_q <= (pos_q == last_pos) ? '0 : pos_q + 1'b1;
				if (rd_vld_q) begin
					if (rd_st == rrls_pkg::ST_RUNNABLE || rd_st == rrls_pkg::ST_RUNNING
						|| rd_st == rrls_pkg::ST_DYING) live_q <= 1'b1;
					if (rd_runnable) begin
						total_q <= total_q + SW'(rd_tk);
						if (!found_q && !policy_q) begin
							found_q <= 1'b1;
							pick_q <= rd_pos_q;
						end
					end
				end
				if (state_d != state_q) pos_q <= '0;
			end
			rrls_pkg::S_LCG_MUL: prod_q <= lcg_q * rrls_pkg::LCG_MUL;
			rrls_pkg::S_MOD: if (div_done) draw_q <= div_rem;
			rrls_pkg::S_PICK: begin
				rd_pos_q <= pos_q;
				pos_q <= pos_q + 1'b1;
				if (rd_runnable && !found_q) begin
					sum_q <= sum_next;
					if (sum_next > draw_q) begin
						found_q <= 1'b1;
						pick_q <= rd_pos_q;
					end
				end
			end
			rrls_pkg::S_DECIDE: begin
				if (found_q) begin
					out_q <= rrls_pkg::OUT_RUN;
					idx_q <= 10'(pick_q);
				end else if (cur_ok_q && rd_st == rrls_pkg::ST_RUNNING) begin
					out_q <= rrls_pkg::OUT_RERUN;
					idx_q <= cur_q;
				end else if (live_q) begin
					out_q <= rrls_pkg::OUT_HALT;
				end else begin
					out_q <= rrls_pkg::OUT_NOLIVE;
				end
			end
			default: ;
		endcase
	end

	assign busy = state_q != rrls_pkg::S_IDLE;
	assign done = done_q;
	assign outcome = out_q;
	assign chosen_index = idx_q;
endmodule

/* hdl/rrls_divider.sv */
`timescale 1ns / 1ps
// Restoring divider: one quotient bit per cycle, remainder only.
module rrls_divider #(
	parameter int unsigned W = 31,
	parameter int unsigned DW = 24
) (
	input logic clk,
	input logic arst_n,
	input logic go,
	input logic [W-1:0] dividend,
	input logic [DW-1:0] divisor,
	output logic done,
	output logic [DW-1:0] remainder
);
	localparam int unsigned CW = $clog2(W + 1);
	logic [W-1:0] num_q;
	logic [DW:0] rem_q;
	logic [DW-1:0] div_q;
	logic [CW-1:0] cnt_q;
	logic run_q;
	logic [DW:0] trial;
	logic [DW+1:0] diff;

	// Shift in the next dividend bit and try a subtract.
	always_comb begin
		trial = {rem_q[DW-1:0], num_q[W-1]};
		diff = {1'b0, trial} - {2'b00, div_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q <= 1'b0;
			cnt_q <= '0;
		end else if (go) begin
			run_q <= 1'b1;
			cnt_q <= CW'(W);
		end else if (run_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CW'(1)) run_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (go) begin
			num_q <= dividend;
			div_q <= divisor;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= {num_q[W-2:0], 1'b0};
			rem_q <= diff[DW+1] ? trial : diff[DW:0];
		end
	end

	assign done = run_q && cnt_q == CW'(1);
	assign remainder = diff[DW+1] ? trial[DW-1:0] : diff[DW-1:0];
endmodule

/* hdl/rrls_checker.sv */
`timescale 1ns / 1ps
// Port-level checks for the scheduler.
module rrls_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [2:0] outcome,
	input logic [9:0] chosen_index
);
	// An accepted item always makes the block busy next cycle.
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy) else $error("accepted item did not raise busy");
	// A result ends the busy period.
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy) else $error("result while busy");
	// Results are single-cycle pulses.
	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done) else $error("result held two cycles");
	// Write, halt and no-live outcomes carry index zero.
	a_halt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && (outcome == rrls_pkg::OUT_HALT || outcome == rrls_pkg::OUT_NOLIVE
		|| outcome == rrls_pkg::OUT_WRITTEN)
		|-> chosen_index == 10'd0) else $error("nonzero index on idle outcome");
endmodule

bind round_robin_lottery_scheduler_top rrls_checker u_rrls_checker (
	.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .done(done),
	.outcome(outcome), .chosen_index(chosen_index)
);

/* test/round_robin_lottery_scheduler_top_test.sv */
`timescale 1ns / 1ps
module round_robin_lottery_scheduler_top_test;
	localparam logic FN_WRITE = 1'b0;
	localparam logic FN_YIELD = 1'b1;
	localparam logic MODE_RR = 1'b0;
	localparam logic MODE_LOTTERY = 1'b1;
	localparam logic [2:0] ST_FREE = 3'd0;
	localparam logic [2:0] ST_BLOCKED = 3'd4;
	localparam int unsigned N_ENTRIES = 1024;

	typedef struct packed {
		logic [2:0] outcome;
		logic [9:0] chosen;
	} decision_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic cfg_wdata = 1'b0;
	logic func = 1'b0;
	logic [9:0] entry_index = '0;
	logic [2:0] entry_status = '0;
	logic [7:0] entry_tickets = '0;
	logic has_current = 1'b0;
	logic [9:0] current_index = '0;
	logic done;
	logic [2:0] outcome;
	logic [9:0] chosen_index;

	// shadow scheduler state
	logic [2:0] task_status [N_ENTRIES];
	logic [7:0] task_tickets [N_ENTRIES];
	logic [30:0] park_miller;
	logic sched_mode;

	decision_t pending_decisions[$];
	int mismatches = 0;
	logic [9:0] hot_entries [16];

	round_robin_lottery_scheduler_top DUT (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata),
		.func(func),
		.entry_index(entry_index),
		.entry_status(entry_status),
		.entry_tickets(entry_tickets),
		.has_current(has_current),
		.current_index(current_index),
		.done(done),
		.outcome(outcome),
		.chosen_index(chosen_index)
	);

	always #4 clk = ~clk;

	// work out the decision of one item and update the shadow state
	task automatic schedule_decision(input logic f, input logic [9:0] idx,
			input logic [2:0] st, input logic [7:0] tk, input logic hc,
			input logic [9:0] cur, output decision_t d);
		int unsigned total;
		int unsigned acc;
		int unsigned draw;
		int unsigned pos;
		logic found;
		logic live;
		longint unsigned prod;
		d = '0;
		found = 1'b0;
		if (f == FN_WRITE) begin
			task_status[idx] = st;
			task_tickets[idx] = tk;
			d.outcome = rrls_pkg::OUT_WRITTEN;
			return;
		end
		if (sched_mode == MODE_LOTTERY) begin
			total = 0;
			for (int i = 0; i < N_ENTRIES; i++)
				if (task_status[i] == rrls_pkg::ST_RUNNABLE) total += task_tickets[i];
			if (total != 0) begin
				prod = longint'(park_miller) * 48271;
				park_miller = 31'(prod % 64'h7fffffff);
				draw = park_miller % total;
				acc = 0;
				for (int i = 0; i < N_ENTRIES && !found; i++) begin
					if (task_status[i] == rrls_pkg::ST_RUNNABLE) begin
						acc += task_tickets[i];
						if (acc > draw) begin
							found = 1'b1;
							d.chosen = 10'(i);
						end
					end
				end
			end
		end else begin
			pos = hc ? cur + 1 : 0;
			for (int n = 0; n < N_ENTRIES && !found; n++) begin
				if (pos >= N_ENTRIES) pos = 0;
				if (task_status[pos] == rrls_pkg::ST_RUNNABLE) begin
					found = 1'b1;
					d.chosen = 10'(pos);
				end
				pos++;
			end
		end
		if (found) begin
			d.outcome = rrls_pkg::OUT_RUN;
			return;
		end
		if (hc && task_status[cur] == rrls_pkg::ST_RUNNING) begin
			d.outcome = rrls_pkg::OUT_RERUN;
			d.chosen = cur;
			return;
		end
		live = 1'b0;
		for (int i = 0; i < N_ENTRIES; i++)
			if (task_status[i] inside {rrls_pkg::ST_RUNNABLE, rrls_pkg::ST_RUNNING,
				rrls_pkg::ST_DYING}) live = 1'b1;
		d.outcome = live ? rrls_pkg::OUT_HALT : rrls_pkg::OUT_NOLIVE;
	endtask

	// drive one item, hold until taken, then idle a random number of cycles
	task automatic send_item(input logic f, input logic [9:0] idx, input logic [2:0] st,
			input logic [7:0] tk, input logic hc, input logic [9:0] cur);
		decision_t d;
		int gap;
		@(negedge clk);
		func <= f;
		entry_index <= idx;
		entry_status <= st;
		entry_tickets <= tk;
		has_current <= hc;
		current_index <= cur;
		start <= 1'b1;
		do @(posedge clk); while (busy);
		schedule_decision(f, idx, st, tk, hc, cur, d);
		pending_decisions.push_back(d);
		gap = $urandom_range(0, 14);
		if (gap > 0) begin
			@(negedge clk);
			start <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
	endtask

	// drain outstanding items, then write the policy register
	task automatic set_policy(input logic mode);
		@(negedge clk);
		start <= 1'b0;
		while (pending_decisions.size() != 0 || busy) @(posedge clk);
		repeat (4) @(posedge clk);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk);
		cfg_we <= 1'b0;
		sched_mode = mode;
	endtask

	// compare each result with the oldest expectation
	always @(posedge clk) begin
		decision_t want;
		if (done) begin
			if (pending_decisions.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result outcome=%0d chosen=%0d", outcome, chosen_index);
			end else begin
				want = pending_decisions.pop_front();
				if (outcome !== want.outcome || chosen_index !== want.chosen) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: expected outcome=%0d chosen=%0d, got outcome=%0d chosen=%0d",
							want.outcome, want.chosen, outcome, chosen_index);
				end
			end
		end
	end

	task automatic test_empty_and_rerun;
		send_item(FN_YIELD, 10'd0, ST_FREE, 8'd0, 1'b0, 10'd0);
		send_item(FN_WRITE, 10'd1023, rrls_pkg::ST_RUNNING, 8'd255, 1'b0, 10'd0);
		send_item(FN_YIELD, 10'd1023, 3'd7, 8'd255, 1'b1, 10'd1023);
		send_item(FN_YIELD, 10'd0, ST_FREE, 8'd0, 1'b0, 10'd0);
		send_item(FN_WRITE, 10'd5, rrls_pkg::ST_RUNNABLE, 8'd0, 1'b0, 10'd0);
		// only runnable entry is the current one: scanned last, still chosen
		send_item(FN_YIELD, 10'd0, ST_FREE, 8'd0, 1'b1, 10'd5);
	endtask

	task automatic test_status_codes;
		send_item(FN_WRITE, 10'd0, 3'd7, 8'd255, 1'b1, 10'd1023);
		send_item(FN_WRITE, 10'd1, rrls_pkg::ST_DYING, 8'd170, 1'b0, 10'd0);
		send_item(FN_WRITE, 10'd2, ST_BLOCKED, 8'd85, 1'b0, 10'd0);
		send_item(FN_WRITE, 10'd3, 3'd5, 8'd1, 1'b0, 10'd0);
		send_item(FN_WRITE, 10'd4, 3'd6, 8'd128, 1'b0, 10'd0);
		send_item(FN_YIELD, 10'd0, ST_FREE, 8'd0, 1'b1, 10'd1);
	endtask

	task automatic test_lottery_edges;
		set_policy(MODE_LOTTERY);
		// runnable tickets sum to zero: generator holds, fall back to rerun
		send_item(FN_YIELD, 10'd0, ST_FREE, 8'd0, 1'b1, 10'd1023);
		send_item(FN_WRITE, 10'd5, rrls_pkg::ST_RUNNABLE, 8'd255, 1'b0, 10'd0);
		send_item(FN_WRITE, 10'd0, rrls_pkg::ST_RUNNABLE, 8'd1, 1'b0, 10'd0);
		send_item(FN_YIELD, 10'd0, ST_FREE, 8'd0, 1'b0, 10'd0);
		send_item(FN_YIELD, 10'd0, ST_FREE, 8'd0, 1'b1, 10'd512);
		send_item(FN_WRITE, 10'd5, ST_FREE, 8'd0, 1'b0, 10'd0);
		send_item(FN_WRITE, 10'd0, ST_FREE, 8'd0, 1'b0, 10'd0);
		send_item(FN_WRITE, 10'd1023, ST_FREE, 8'd0, 1'b0, 10'd0);
		send_item(FN_WRITE, 10'd1, ST_FREE, 8'd0, 1'b0, 10'd0);
		send_item(FN_YIELD, 10'd0, ST_FREE, 8'd0, 1'b0, 10'd0);
		set_policy(MODE_RR);
	endtask

	// mostly writes into a small set of hot entries, with rarer yields
	task automatic test_random_mix;
		logic [2:0] st;
		logic [9:0] idx;
		for (int i = 0; i < 16; i++) hot_entries[i] = 10'($urandom_range(0, 1023));
		hot_entries[0] = 10'd0;
		hot_entries[1] = 10'd1023;
		for (int n = 0; n < 280; n++) begin
			if (n % 70 == 0) set_policy((n / 70) % 2 == 0 ? MODE_LOTTERY : MODE_RR);
			st = ($urandom_range(0, 2) == 0) ? 3'($urandom_range(0, 7)) : rrls_pkg::ST_RUNNABLE;
			if ($urandom_range(0, 3) == 0) st = rrls_pkg::ST_RUNNING;
			idx = ($urandom_range(0, 7) == 0) ? 10'($urandom) : hot_entries[$urandom_range(0, 15)];
			if ($urandom_range(0, 3) == 0)
				send_item(FN_YIELD, 10'($urandom), 3'($urandom), 8'($urandom),
					1'($urandom), ($urandom_range(0, 3) == 0) ? 10'($urandom)
					: hot_entries[$urandom_range(0, 15)]);
			else
				send_item(FN_WRITE, idx, st, 8'($urandom), 1'($urandom), 10'($urandom));
		end
	endtask

	initial begin
		for (int i = 0; i < N_ENTRIES; i++) begin
			task_status[i] = ST_FREE;
			task_tickets[i] = '0;
		end
		park_miller = 31'd1;
		sched_mode = MODE_RR;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_empty_and_rerun();
		test_status_codes();
		test_lottery_edges();
		test_random_mix();
		@(negedge clk);
		start <= 1'b0;
		while (pending_decisions.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (mismatches == 0 && pending_decisions.size() == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	// hang guard
	initial begin
		#20ms;
		$display("status: fail");
		$finish;
	end
endmodule
